// ===== rtl/h2r_pkg.sv =====
package h2r_pkg;

  // Fixed field widths of the channels.
  localparam int IN_W  = 18;
  localparam int OUT_W = 17;

  // Mode code carried with each transaction.
  localparam logic MODE_RGB = 1'b0;
  localparam logic MODE_HSV = 1'b1;

  // Hue sector, named after the color at the start of the sector.
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } h2r_sector_t;

  // Control that travels with the data from stage to stage.
  typedef struct packed {
    logic valid;
    logic hsv;
  } h2r_ctl_t;

endpackage

// ===== rtl/h2r_in_if.sv =====
interface h2r_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [h2r_pkg::IN_W-1:0]   red_or_hue;
  logic signed [h2r_pkg::IN_W-1:0]   green_or_saturation;
  logic signed [h2r_pkg::IN_W-1:0]   blue_or_value;
  logic signed [h2r_pkg::IN_W-1:0]   alpha_in;
  logic                              mode;

  modport source (
    output valid, red_or_hue, green_or_saturation, blue_or_value, alpha_in, mode,
    input  ready
  );

  modport sink (
    input  valid, red_or_hue, green_or_saturation, blue_or_value, alpha_in, mode,
    output ready
  );
endinterface

// ===== rtl/h2r_out_if.sv =====
interface h2r_out_if;
  logic                        valid;
  logic                        ready;
  logic [h2r_pkg::OUT_W-1:0]   red_out;
  logic [h2r_pkg::OUT_W-1:0]   green_out;
  logic [h2r_pkg::OUT_W-1:0]   blue_out;
  logic [h2r_pkg::OUT_W-1:0]   alpha_out;

  modport source (
    output valid, red_out, green_out, blue_out, alpha_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out, alpha_out,
    output ready
  );
endinterface

// ===== rtl/h2r_clamp.sv =====
module h2r_clamp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             valid_i,
  input  logic                             mode_i,
  input  logic signed [h2r_pkg::IN_W-1:0]  hue_i,
  input  logic signed [h2r_pkg::IN_W-1:0]  sat_i,
  input  logic signed [h2r_pkg::IN_W-1:0]  val_i,
  input  logic signed [h2r_pkg::IN_W-1:0]  alpha_i,
  output logic                             rdy_o,
  input  logic                             rdy_i,
  output h2r_pkg::h2r_ctl_t                ctl_o,
  output logic [((FRAC_BITS + 1 < h2r_pkg::IN_W - 1) ? FRAC_BITS + 1 : h2r_pkg::IN_W - 1) - 1:0]
                                           h_o, s_o, v_o, a_o
);
  import h2r_pkg::*;

  // Clamped values are at most 1.0 and at most the largest positive input.
  localparam int CW   = (FRAC_BITS + 1 < IN_W - 1) ? FRAC_BITS + 1 : IN_W - 1;
  localparam int CMPW = (FRAC_BITS + 1 > IN_W - 1) ? FRAC_BITS + 1 : IN_W - 1;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  h2r_ctl_t        ctl_r;
  logic [CW-1:0]   h_r, s_r, v_r, a_r;

  function automatic logic [CW-1:0] clamp_unit(input logic [IN_W-1:0] raw);
    logic [CMPW-1:0] mag;
    logic [CW-1:0]   res;
    mag = CMPW'(raw[IN_W-2:0]);
    if (raw[IN_W-1]) begin
      res = '0;
    end else if (mag > CMPW'(ONE)) begin
      res = CW'(ONE);
    end else begin
      res = CW'(mag);
    end
    return res;
  endfunction

  // The stage takes a new transaction when empty or when its content moves on.
  assign rdy_o = !ctl_r.valid || rdy_i;

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (rdy_o) begin
      ctl_r.valid <= valid_i;
    end
  end

  // Clamp all four components into [0, 1.0].
  always_ff @(posedge clk) begin
    if (rdy_o && valid_i) begin
      ctl_r.hsv <= (mode_i == MODE_HSV);
      h_r       <= clamp_unit($unsigned(hue_i));
      s_r       <= clamp_unit($unsigned(sat_i));
      v_r       <= clamp_unit($unsigned(val_i));
      a_r       <= clamp_unit($unsigned(alpha_i));
    end
  end

  assign ctl_o = ctl_r;
  assign h_o   = h_r;
  assign s_o   = s_r;
  assign v_o   = v_r;
  assign a_o   = a_r;

endmodule

// ===== rtl/h2r_chroma.sv =====
module h2r_chroma #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  h2r_pkg::h2r_ctl_t     ctl_i,
  input  logic [((FRAC_BITS + 1 < h2r_pkg::IN_W - 1) ? FRAC_BITS + 1 : h2r_pkg::IN_W - 1) - 1:0]
                                h_i, s_i, v_i, a_i,
  output logic                  rdy_o,
  input  logic                  rdy_i,
  output h2r_pkg::h2r_ctl_t     ctl_o,
  output h2r_pkg::h2r_sector_t  sector_o,
  output logic [FRAC_BITS:0]    omd_o,
  output logic [((FRAC_BITS + 1 < h2r_pkg::IN_W - 1) ? FRAC_BITS + 1 : h2r_pkg::IN_W - 1) - 1:0]
                                c_o, h_o, s_o, v_o, a_o
);
  import h2r_pkg::*;

  localparam int CW  = (FRAC_BITS + 1 < IN_W - 1) ? FRAC_BITS + 1 : IN_W - 1;
  localparam int H6W = CW + 3;
  localparam int MW  = FRAC_BITS + 1;

  h2r_ctl_t        ctl_r;
  h2r_sector_t     sector_r, sector_nxt;
  logic [MW-1:0]   omd_r, omd_nxt;
  logic [CW-1:0]   c_r, c_nxt;
  logic [CW-1:0]   h_r, s_r, v_r, a_r;
  logic [H6W-1:0]  h6, sec_raw;
  logic [MW-1:0]   mod2;
  logic [2*CW-1:0] prod_sv;

  // Scaled hue picks the sector; its position inside a pair of sectors gives
  // one minus the distance from the pair's center.
  always_comb begin
    h6      = H6W'({h_i, 2'b00}) + H6W'({h_i, 1'b0});
    sec_raw = h6 >> FRAC_BITS;
    if (sec_raw > H6W'(SEC_MAGENTA)) begin
      sector_nxt = SEC_MAGENTA;
    end else begin
      sector_nxt = h2r_sector_t'(sec_raw[2:0]);
    end
    mod2    = MW'(h6);
    omd_nxt = mod2[FRAC_BITS] ? (MW'(0) - mod2) : mod2;
  end

  // Chroma is saturation times value, truncated.
  always_comb begin
    prod_sv = (2*CW)'(s_i) * (2*CW)'(v_i);
    c_nxt   = CW'(prod_sv >> FRAC_BITS);
  end

  assign rdy_o = !ctl_r.valid || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (rdy_o) begin
      ctl_r.valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && ctl_i.valid) begin
      ctl_r.hsv <= ctl_i.hsv;
      sector_r  <= sector_nxt;
      omd_r     <= omd_nxt;
      c_r       <= c_nxt;
      h_r       <= h_i;
      s_r       <= s_i;
      v_r       <= v_i;
      a_r       <= a_i;
    end
  end

  assign ctl_o    = ctl_r;
  assign sector_o = sector_r;
  assign omd_o    = omd_r;
  assign c_o      = c_r;
  assign h_o      = h_r;
  assign s_o      = s_r;
  assign v_o      = v_r;
  assign a_o      = a_r;

endmodule

// ===== rtl/h2r_secondary.sv =====
module h2r_secondary #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  h2r_pkg::h2r_ctl_t     ctl_i,
  input  h2r_pkg::h2r_sector_t  sector_i,
  input  logic [FRAC_BITS:0]    omd_i,
  input  logic [((FRAC_BITS + 1 < h2r_pkg::IN_W - 1) ? FRAC_BITS + 1 : h2r_pkg::IN_W - 1) - 1:0]
                                c_i, h_i, s_i, v_i, a_i,
  output logic                  rdy_o,
  input  logic                  rdy_i,
  output h2r_pkg::h2r_ctl_t     ctl_o,
  output h2r_pkg::h2r_sector_t  sector_o,
  output logic [((FRAC_BITS + 1 < h2r_pkg::IN_W - 1) ? FRAC_BITS + 1 : h2r_pkg::IN_W - 1) - 1:0]
                                x_o, c_o, m_o, h_o, s_o, v_o, a_o
);
  import h2r_pkg::*;

  localparam int CW = (FRAC_BITS + 1 < IN_W - 1) ? FRAC_BITS + 1 : IN_W - 1;
  localparam int PW = CW + FRAC_BITS + 1;

  h2r_ctl_t       ctl_r;
  h2r_sector_t    sector_r;
  logic [CW-1:0]  x_r, x_nxt;
  logic [CW-1:0]  m_r, m_nxt;
  logic [CW-1:0]  c_r, h_r, s_r, v_r, a_r;
  logic [PW-1:0]  prod_x;

  // Secondary term and the offset that lifts all three channels.
  always_comb begin
    prod_x = PW'(c_i) * PW'(omd_i);
    x_nxt  = CW'(prod_x >> FRAC_BITS);
    m_nxt  = v_i - c_i;
  end

  assign rdy_o = !ctl_r.valid || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (rdy_o) begin
      ctl_r.valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && ctl_i.valid) begin
      ctl_r.hsv <= ctl_i.hsv;
      sector_r  <= sector_i;
      x_r       <= x_nxt;
      m_r       <= m_nxt;
      c_r       <= c_i;
      h_r       <= h_i;
      s_r       <= s_i;
      v_r       <= v_i;
      a_r       <= a_i;
    end
  end

  assign ctl_o    = ctl_r;
  assign sector_o = sector_r;
  assign x_o      = x_r;
  assign c_o      = c_r;
  assign m_o      = m_r;
  assign h_o      = h_r;
  assign s_o      = s_r;
  assign v_o      = v_r;
  assign a_o      = a_r;

endmodule

// ===== rtl/h2r_assemble.sv =====
module h2r_assemble #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  h2r_pkg::h2r_ctl_t          ctl_i,
  input  h2r_pkg::h2r_sector_t       sector_i,
  input  logic [((FRAC_BITS + 1 < h2r_pkg::IN_W - 1) ? FRAC_BITS + 1 : h2r_pkg::IN_W - 1) - 1:0]
                                     x_i, c_i, m_i, h_i, s_i, v_i, a_i,
  output logic                       rdy_o,
  input  logic                       rdy_i,
  output logic                       valid_o,
  output logic [h2r_pkg::OUT_W-1:0]  red_o,
  output logic [h2r_pkg::OUT_W-1:0]  green_o,
  output logic [h2r_pkg::OUT_W-1:0]  blue_o,
  output logic [h2r_pkg::OUT_W-1:0]  alpha_o
);
  import h2r_pkg::*;

  localparam int CW = (FRAC_BITS + 1 < IN_W - 1) ? FRAC_BITS + 1 : IN_W - 1;

  logic              valid_r;
  logic [OUT_W-1:0]  red_r, green_r, blue_r, alpha_r;
  logic [CW-1:0]     red_sel, green_sel, blue_sel;
  logic [CW-1:0]     red_sum, green_sum, blue_sum;
  logic [CW-1:0]     top_sum;

  // Sector decoder: which channel gets chroma, which the secondary term.
  always_comb begin
    unique case (sector_i)
      SEC_RED: begin
        red_sel = c_i;  green_sel = x_i;  blue_sel = '0;
      end
      SEC_YELLOW: begin
        red_sel = x_i;  green_sel = c_i;  blue_sel = '0;
      end
      SEC_GREEN: begin
        red_sel = '0;   green_sel = c_i;  blue_sel = x_i;
      end
      SEC_CYAN: begin
        red_sel = '0;   green_sel = x_i;  blue_sel = c_i;
      end
      SEC_BLUE: begin
        red_sel = x_i;  green_sel = '0;   blue_sel = c_i;
      end
      default: begin
        red_sel = c_i;  green_sel = '0;   blue_sel = x_i;
      end
    endcase
  end

  // Add the offset in HSV mode, pass the clamped components in RGB mode.
  always_comb begin
    top_sum = c_i + m_i;
    if (ctl_i.hsv) begin
      red_sum   = red_sel + m_i;
      green_sum = green_sel + m_i;
      blue_sum  = blue_sel + m_i;
    end else begin
      red_sum   = h_i;
      green_sum = s_i;
      blue_sum  = v_i;
    end
  end

  // Output register; it accepts a new transaction when empty or while the old one is taken.
  assign rdy_o = !valid_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rdy_o) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && ctl_i.valid) begin
      red_r   <= OUT_W'(red_sum);
      green_r <= OUT_W'(green_sum);
      blue_r  <= OUT_W'(blue_sum);
      alpha_r <= OUT_W'(a_i);
    end
  end

  assign valid_o = valid_r;
  assign red_o   = red_r;
  assign green_o = green_r;
  assign blue_o  = blue_r;
  assign alpha_o = alpha_r;

`ifndef NO_ASSERTIONS
  // The secondary term never exceeds chroma.
  a_x_le_c: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_i.valid && ctl_i.hsv) |-> (x_i <= c_i))
    else $error("secondary term exceeds chroma");

  // In HSV mode one channel sits at the offset, the minimum of the color.
  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_i.valid && ctl_i.hsv) |->
      (red_sum == m_i || green_sum == m_i || blue_sum == m_i))
    else $error("no channel at the offset");

  // In HSV mode one channel reaches chroma plus offset, the value.
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_i.valid && ctl_i.hsv) |->
      (red_sum == top_sum || green_sum == top_sum || blue_sum == top_sum))
    else $error("no channel at the value");
`endif

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// Throughput: one transaction per cycle while the output channel is ready, through
// four register stages
// (clamp, sector and chroma, secondary term, channel assembly).
// Each stage holds its content while stalled and refills when it moves on.
// Reset is synchronous and active low; it clears the stage valid bits only.
module hsv_to_rgb_converter #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  h2r_in_if.sink     in_ch,
  h2r_out_if.source  out_ch
);
  import h2r_pkg::*;

  localparam int CW = (FRAC_BITS + 1 < IN_W - 1) ? FRAC_BITS + 1 : IN_W - 1;

  h2r_ctl_t       ctl_s1, ctl_s2, ctl_s3;
  h2r_sector_t    sector_s2, sector_s3;
  logic           rdy_s1, rdy_s2, rdy_s3, rdy_s4;
  logic [CW-1:0]  h_s1, s_s1, v_s1, a_s1;
  logic [CW-1:0]  c_s2, h_s2, s_s2, v_s2, a_s2;
  logic [FRAC_BITS:0] omd_s2;
  logic [CW-1:0]  x_s3, c_s3, m_s3, h_s3, s_s3, v_s3, a_s3;

  assign in_ch.ready = rdy_s1;

  h2r_clamp #(.FRAC_BITS(FRAC_BITS)) u_clamp (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_ch.valid),
    .mode_i  (in_ch.mode),
    .hue_i   (in_ch.red_or_hue),
    .sat_i   (in_ch.green_or_saturation),
    .val_i   (in_ch.blue_or_value),
    .alpha_i (in_ch.alpha_in),
    .rdy_o   (rdy_s1),
    .rdy_i   (rdy_s2),
    .ctl_o   (ctl_s1),
    .h_o     (h_s1),
    .s_o     (s_s1),
    .v_o     (v_s1),
    .a_o     (a_s1)
  );

  h2r_chroma #(.FRAC_BITS(FRAC_BITS)) u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl_s1),
    .h_i      (h_s1),
    .s_i      (s_s1),
    .v_i      (v_s1),
    .a_i      (a_s1),
    .rdy_o    (rdy_s2),
    .rdy_i    (rdy_s3),
    .ctl_o    (ctl_s2),
    .sector_o (sector_s2),
    .omd_o    (omd_s2),
    .c_o      (c_s2),
    .h_o      (h_s2),
    .s_o      (s_s2),
    .v_o      (v_s2),
    .a_o      (a_s2)
  );

  h2r_secondary #(.FRAC_BITS(FRAC_BITS)) u_secondary (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl_s2),
    .sector_i (sector_s2),
    .omd_i    (omd_s2),
    .c_i      (c_s2),
    .h_i      (h_s2),
    .s_i      (s_s2),
    .v_i      (v_s2),
    .a_i      (a_s2),
    .rdy_o    (rdy_s3),
    .rdy_i    (rdy_s4),
    .ctl_o    (ctl_s3),
    .sector_o (sector_s3),
    .x_o      (x_s3),
    .c_o      (c_s3),
    .m_o      (m_s3),
    .h_o      (h_s3),
    .s_o      (s_s3),
    .v_o      (v_s3),
    .a_o      (a_s3)
  );

  h2r_assemble #(.FRAC_BITS(FRAC_BITS)) u_assemble (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl_s3),
    .sector_i (sector_s3),
    .x_i      (x_s3),
    .c_i      (c_s3),
    .m_i      (m_s3),
    .h_i      (h_s3),
    .s_i      (s_s3),
    .v_i      (v_s3),
    .a_i      (a_s3),
    .rdy_o    (rdy_s4),
    .rdy_i    (out_ch.ready),
    .valid_o  (out_ch.valid),
    .red_o    (out_ch.red_out),
    .green_o  (out_ch.green_out),
    .blue_o   (out_ch.blue_out),
    .alpha_o  (out_ch.alpha_out)
  );

endmodule

// ===== verif/hsv_to_rgb_converter_test.sv =====
`timescale 1ns / 100ps

module hsv_to_rgb_converter_test;
  import h2r_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int ONE = 1 << FRAC_BITS;
  localparam int LONG_HOLD = 64;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;

  // One color transaction as offered on the input channel.
  typedef struct packed {
    logic signed [IN_W-1:0] red_or_hue;
    logic signed [IN_W-1:0] green_or_saturation;
    logic signed [IN_W-1:0] blue_or_value;
    logic signed [IN_W-1:0] alpha_in;
    logic                   mode;
  } color_t;

  // One result transaction as seen on the output channel.
  typedef struct packed {
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
    logic [OUT_W-1:0] alpha_out;
  } rgba_t;

  // Scoreboard: predicts the RGBA result of each accepted color and checks
  // the results in order.
  class rgba_scoreboard;
    rgba_t expected_rgba_q[$];
    int    mismatch_count;

    // Clamp a signed component to the unit range [0, 1.0].
    function logic [63:0] clamp_unit(logic signed [IN_W-1:0] raw);
      if (raw < 0) return 64'd0;
      if (raw > IN_W'(ONE)) return 64'(ONE);
      return {{(64-IN_W){1'b0}}, raw};
    endfunction

    function rgba_t predict_rgba(color_t c);
      logic [63:0] hue, sat, val, h6, sector_idx, mod2, fold_dist;
      logic [63:0] chroma, second, offset, r, g, b;
      h2r_sector_t sector;
      rgba_t want;
      hue = clamp_unit(c.red_or_hue);
      sat = clamp_unit(c.green_or_saturation);
      val = clamp_unit(c.blue_or_value);
      if (c.mode == MODE_HSV) begin
        // Scaled hue picks the sector; its distance from an odd boundary
        // sets the secondary term.
        h6 = hue * 64'd6;
        sector_idx = h6 >> FRAC_BITS;
        if (sector_idx > 5) sector_idx = 5;
        sector = h2r_sector_t'(sector_idx[2:0]);
        mod2 = h6 & (64'(2 * ONE) - 64'd1);
        fold_dist = (mod2 >= 64'(ONE)) ? (mod2 - 64'(ONE)) : (64'(ONE) - mod2);
        chroma = (sat * val) >> FRAC_BITS;
        second = (chroma * (64'(ONE) - fold_dist)) >> FRAC_BITS;
        offset = val - chroma;
        case (sector)
          SEC_RED: begin
            r = chroma; g = second; b = 0;
          end
          SEC_YELLOW: begin
            r = second; g = chroma; b = 0;
          end
          SEC_GREEN: begin
            r = 0; g = chroma; b = second;
          end
          SEC_CYAN: begin
            r = 0; g = second; b = chroma;
          end
          SEC_BLUE: begin
            r = second; g = 0; b = chroma;
          end
          default: begin
            r = chroma; g = 0; b = second;
          end
        endcase
        r += offset;
        g += offset;
        b += offset;
      end else begin
        r = hue;
        g = sat;
        b = val;
      end
      want.red_out   = r[OUT_W-1:0];
      want.green_out = g[OUT_W-1:0];
      want.blue_out  = b[OUT_W-1:0];
      want.alpha_out = OUT_W'(clamp_unit(c.alpha_in));
      return want;
    endfunction

    function void note_color(color_t c);
      expected_rgba_q.push_back(predict_rgba(c));
    endfunction

    function void check_rgba(rgba_t got);
      rgba_t want;
      if (expected_rgba_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: r=%0d g=%0d b=%0d a=%0d",
                   got.red_out, got.green_out, got.blue_out, got.alpha_out);
        return;
      end
      want = expected_rgba_q.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                   want.red_out, want.green_out, want.blue_out, want.alpha_out,
                   got.red_out, got.green_out, got.blue_out, got.alpha_out);
      end
    endfunction

    function int pending();
      return expected_rgba_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_idle_en;
  logic out_idle_en;
  logic hold_req;
  int   idle_cycles;

  rgba_scoreboard sb = new();

  h2r_in_if  in_bus();
  h2r_out_if out_bus();

  hsv_to_rgb_converter #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor both channels at the rising edge. Results are checked before
  // the input of the same edge is noted, and a stuck pipeline trips the
  // watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready)
        sb.check_rgba({out_bus.red_out, out_bus.green_out, out_bus.blue_out,
                       out_bus.alpha_out});
      if (in_bus.valid && in_bus.ready)
        sb.note_color({in_bus.red_or_hue, in_bus.green_or_saturation,
                       in_bus.blue_or_value, in_bus.alpha_in, in_bus.mode});
      if ((out_bus.valid && out_bus.ready) || (in_bus.valid && in_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("[hsv_to_rgb_converter] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  // Result receiver: random stalls per transaction, plus one long hold-off
  // on request so that the pipeline fills and backs up into the input.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && rst_n) begin
        out_bus.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = out_idle_en ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_bus.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready = 1'b1;
      do @(posedge clk); while (!(out_bus.valid && rst_n));
    end
  end

  function color_t make_color(int h, int s, int v, int a, logic mode);
    color_t c;
    c.red_or_hue          = IN_W'(h);
    c.green_or_saturation = IN_W'(s);
    c.blue_or_value       = IN_W'(v);
    c.alpha_in            = IN_W'(a);
    c.mode                = mode;
    return c;
  endfunction

  // Mostly in-range values, some edges, some fully random bit patterns.
  function logic signed [IN_W-1:0] random_component();
    case ($urandom_range(0, 9))
      0: return IN_W'($urandom);
      1: begin
        case ($urandom_range(0, 7))
          0: return IN_W'(-131072);
          1: return IN_W'(131071);
          2: return IN_W'(-1);
          3: return IN_W'(0);
          4: return IN_W'(ONE);
          5: return IN_W'(ONE - 1);
          6: return IN_W'(ONE + 1);
          default: return IN_W'(32768);
        endcase
      end
      default: return IN_W'($urandom_range(0, ONE));
    endcase
  endfunction

  // Offer one color, after a random gap if input idling is on, and wait until it is taken.
  task send_color(input color_t c);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.red_or_hue          = c.red_or_hue;
    in_bus.green_or_saturation = c.green_or_saturation;
    in_bus.blue_or_value       = c.blue_or_value;
    in_bus.alpha_in            = c.alpha_in;
    in_bus.mode                = c.mode;
    in_bus.valid               = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task send_random(input int count);
    repeat (count)
      send_color({random_component(), random_component(), random_component(),
                  random_component(), logic'($urandom_range(0, 1))});
  endtask

  // Stop offering and wait until every predicted result has been checked.
  task drain_pipeline();
    in_bus.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    hold_req    = 1'b0;
    idle_cycles = 0;
    in_bus.valid               = 1'b0;
    in_bus.red_or_hue          = '0;
    in_bus.green_or_saturation = '0;
    in_bus.blue_or_value       = '0;
    in_bus.alpha_in            = '0;
    in_bus.mode                = MODE_RGB;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: clamping at both ends, pass-through, every sector with
    // its boundaries, hue of exactly one, gray and black.
    send_color(make_color(0, 0, 0, 0, MODE_RGB));
    send_color(make_color(ONE, ONE, ONE, ONE, MODE_RGB));
    send_color(make_color(-131072, 131071, -1, ONE + 1, MODE_RGB));
    send_color(make_color(131071, -131072, ONE - 1, -1, MODE_RGB));
    send_color(make_color(1, ONE - 1, ONE, 131071, MODE_RGB));
    send_color(make_color(0, ONE, ONE, ONE, MODE_HSV));
    send_color(make_color(10922, ONE, ONE, 100, MODE_HSV));
    send_color(make_color(10923, ONE, ONE, ONE, MODE_HSV));
    send_color(make_color(21845, ONE, ONE, ONE, MODE_HSV));
    send_color(make_color(21846, ONE, ONE, ONE, MODE_HSV));
    send_color(make_color(32767, ONE, ONE, ONE, MODE_HSV));
    send_color(make_color(32768, ONE, ONE, ONE, MODE_HSV));
    send_color(make_color(43690, ONE, ONE, ONE, MODE_HSV));
    send_color(make_color(43691, ONE, ONE, ONE, MODE_HSV));
    send_color(make_color(54613, ONE, ONE, ONE, MODE_HSV));
    send_color(make_color(54614, ONE, ONE, ONE, MODE_HSV));
    send_color(make_color(ONE - 1, ONE, ONE, ONE, MODE_HSV));
    send_color(make_color(ONE, ONE, ONE, ONE, MODE_HSV));
    send_color(make_color(ONE, 40000, 50000, 7, MODE_HSV));
    send_color(make_color(131071, -5, 131071, -131072, MODE_HSV));
    send_color(make_color(-131072, ONE, 32768, ONE, MODE_HSV));
    send_color(make_color(20000, 0, 40000, ONE, MODE_HSV));
    send_color(make_color(20000, ONE, 0, ONE, MODE_HSV));
    send_color(make_color(20000, 32768, 32768, 32768, MODE_HSV));
    send_color(make_color(131071, 131071, 131071, 131071, MODE_HSV));

    // Random traffic with gaps on both sides.
    send_random(250);

    // Back to back, no idling anywhere.
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    send_random(200);

    // Long receiver hold-off while the sender keeps offering.
    hold_req = 1'b1;
    send_random(100);
    drain_pipeline();

    // Idling on one side only at a time.
    in_idle_en = 1'b1;
    send_random(150);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b1;
    send_random(150);

    in_bus.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("[hsv_to_rgb_converter] OK");
    end else begin
      $display("[hsv_to_rgb_converter] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/h2r_pkg.sv
rtl/h2r_in_if.sv
rtl/h2r_out_if.sv
rtl/h2r_clamp.sv
rtl/h2r_chroma.sv
rtl/h2r_secondary.sv
rtl/h2r_assemble.sv
rtl/hsv_to_rgb_converter.sv
verif/hsv_to_rgb_converter_test.sv
